// ----- hw/rtl/fstm_pkg.sv -----
// ----------------------------------------------------------------------------
// fstm_pkg
// Shared types and constants for the flat span texture mapper.
// ----------------------------------------------------------------------------
package fstm_pkg;

	// Function codes carried in the input tuser field.
	localparam logic [1:0] FUNC_TEXEL = 2'd0;
	localparam logic [1:0] FUNC_SHADE = 2'd1;
	localparam logic [1:0] FUNC_START = 2'd2;
	localparam logic [1:0] FUNC_DRAW  = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_WINDOW_X = 1'b0;
	localparam logic CFG_WINDOW_Y = 1'b1;

	localparam int SCREEN_WIDTH_DEF = 320;

	localparam int TEX_DEPTH   = 4096;
	localparam int TEX_AW      = 12;
	localparam int SHADE_DEPTH = 256;
	localparam int SHADE_AW    = 8;
	localparam int COLOR_W     = 8;
	localparam int POS_W       = 32;
	localparam int COL_W       = 9;
	localparam int ROW_W       = 8;
	localparam int OFF_W       = 17;

	// Texel coordinate taken from the integer part of a 16.16 position.
	localparam int FRAC_W  = 16;
	localparam int COORD_W = 6;

	localparam int IN_DATA_W  = 176;
	localparam int OUT_DATA_W = 32;

	// Per-pixel control handed from the span sequencer to the pipeline.
	typedef struct packed {
		logic             draw;
		logic             last;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} pix_t;

endpackage

// ----- hw/rtl/fstm_ram.sv -----
// ----------------------------------------------------------------------------
// fstm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fstm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/fstm_span.sv -----
// ----------------------------------------------------------------------------
// fstm_span
// Span sequencer: holds the texture position, steps and column counter.
// ----------------------------------------------------------------------------
module fstm_span (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  logic [1:0]                         func,
	input  logic [fstm_pkg::POS_W-1:0]         u_start,
	input  logic [fstm_pkg::POS_W-1:0]         v_start,
	input  logic [fstm_pkg::POS_W-1:0]         u_step,
	input  logic [fstm_pkg::POS_W-1:0]         v_step,
	input  logic [fstm_pkg::COL_W-1:0]         span_first_x,
	input  logic [fstm_pkg::COL_W-1:0]         span_last_x,
	input  logic [fstm_pkg::ROW_W-1:0]         span_row,
	output logic [fstm_pkg::TEX_AW-1:0]        tex_addr,
	output fstm_pkg::pix_t                     pix
);

	import fstm_pkg::*;

	logic [POS_W-1:0] u_q, v_q, du_q, dv_q;
	logic [COL_W-1:0] col_q, end_q;
	logic [ROW_W-1:0] row_q;
	logic             active_q;
	logic             is_last;
	logic             draw;

	assign is_last = col_q >= end_q;
	assign draw    = accept && (func == FUNC_DRAW) && active_q;

	// Texel address is v[21:16] * 64 + u[21:16] of the current position.
	assign tex_addr = {v_q[FRAC_W +: COORD_W], u_q[FRAC_W +: COORD_W]};

	assign pix.draw = draw;
	assign pix.last = is_last;
	assign pix.col  = col_q;
	assign pix.row  = row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_q      <= '0;
			v_q      <= '0;
			du_q     <= '0;
			dv_q     <= '0;
			col_q    <= '0;
			end_q    <= '0;
			row_q    <= '0;
			active_q <= 1'b0;
		end else if (accept && (func == FUNC_START)) begin
			u_q      <= u_start;
			v_q      <= v_start;
			du_q     <= u_step;
			dv_q     <= v_step;
			col_q    <= span_first_x;
			end_q    <= span_last_x;
			row_q    <= span_row;
			active_q <= span_last_x >= span_first_x;
		end else if (draw) begin
			u_q <= u_q + du_q;
			v_q <= v_q + dv_q;
			if (is_last) begin
				active_q <= 1'b0;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/flat_span_texture_mapper_top.sv -----
// ----------------------------------------------------------------------------
// flat_span_texture_mapper_top
// Affine floor/ceiling span texture mapper with texture and shade tables.
// ----------------------------------------------------------------------------
// Pipeline: a draw beat passes the texture RAM read, the shade RAM read and
// the output register in that order. Throughput: one input beat per cycle and
// one pixel per cycle while the output is not stalled, set by the single read
// port of each table RAM, which is read once per pixel.
// Reset: arst_n clears the span state, window registers and all valid flags.
// The table RAMs are not cleared and hold whatever was last written.
module flat_span_texture_mapper_top #(
	parameter int SCREEN_WIDTH = fstm_pkg::SCREEN_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port.
	input  logic                                cfg_wr_en,
	input  logic                                cfg_index,
	input  logic [8:0]                          cfg_data,
	// Input stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// tdata from bit 0 up: table_index[11:0], table_data[19:12],
	// u_start[51:20], v_start[83:52], u_step[115:84], v_step[147:116],
	// span_first_x[156:148], span_last_x[165:157], span_row[173:166],
	// zero fill[175:174].
	input  logic [fstm_pkg::IN_DATA_W-1:0]      s_tdata,
	// tuser: func[1:0].
	input  logic [1:0]                          s_tuser,
	// Output stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// tdata from bit 0 up: screen_offset[16:0], pixel_color[24:17],
	// zero fill[31:25].
	output logic [fstm_pkg::OUT_DATA_W-1:0]     m_tdata,
	// tlast: last_pixel.
	output logic                                m_tlast
);

	import fstm_pkg::*;

	// Unpacked input fields.
	logic [TEX_AW-1:0]  table_index;
	logic [COLOR_W-1:0] table_data;
	logic [POS_W-1:0]   u_start, v_start, u_step, v_step;
	logic [COL_W-1:0]   span_first_x, span_last_x;
	logic [ROW_W-1:0]   span_row;

	assign table_index  = s_tdata[11:0];
	assign table_data   = s_tdata[19:12];
	assign u_start      = s_tdata[51:20];
	assign v_start      = s_tdata[83:52];
	assign u_step       = s_tdata[115:84];
	assign v_step       = s_tdata[147:116];
	assign span_first_x = s_tdata[156:148];
	assign span_last_x  = s_tdata[165:157];
	assign span_row     = s_tdata[173:166];

	// Window registers; the user must write them only while the block is idle, the block itself does not enforce it.
	logic [COL_W-1:0] window_x_q;
	logic [ROW_W-1:0] window_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_x_q <= '0;
			window_y_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_WINDOW_X: window_x_q <= cfg_data;
				CFG_WINDOW_Y: window_y_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline moves together. It advances whenever the last stage
	// is empty or can hand its pixel to the output register, so the input keeps
	// flowing while an output pixel waits, as long as the last stage is empty.
	logic valid_s1, valid_s2;
	logic m_tvalid_q;
	logic adv;
	logic acc;

	assign adv      = !valid_s2 || !m_tvalid_q || m_tready;
	assign s_tready = adv;
	assign acc      = s_tvalid && adv;

	// Span sequencer: the texel address of the pixel being accepted.
	logic [TEX_AW-1:0] tex_addr;
	pix_t              pix;

	fstm_span u_span (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (acc),
		.func         (s_tuser),
		.u_start      (u_start),
		.v_start      (v_start),
		.u_step       (u_step),
		.v_step       (v_step),
		.span_first_x (span_first_x),
		.span_last_x  (span_last_x),
		.span_row     (span_row),
		.tex_addr     (tex_addr),
		.pix          (pix)
	);

	// Texture RAM: writes and reads both happen at the accept stage, so they
	// are naturally ordered with the input beats.
	logic [COLOR_W-1:0] texel;

	fstm_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (TEX_DEPTH),
		.AW    (TEX_AW)
	) u_tex_ram (
		.clk   (clk),
		.we    (acc && (s_tuser == FUNC_TEXEL)),
		.waddr (table_index),
		.wdata (table_data),
		.re    (adv),
		.raddr (tex_addr),
		.rdata (texel)
	);

	// Stage 1: texel is available. Shade writes are delayed to this stage so
	// that they stay in order with the shade reads of earlier pixels.
	logic               last_s1;
	logic [COL_W-1:0]   col_s1;
	logic [ROW_W-1:0]   row_s1;
	logic               shade_we_s1;
	logic [SHADE_AW-1:0] shade_idx_s1;
	logic [COLOR_W-1:0] shade_dat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			shade_we_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1    <= pix.draw;
			shade_we_s1 <= acc && (s_tuser == FUNC_SHADE);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1      <= pix.last;
			col_s1       <= pix.col;
			row_s1       <= pix.row;
			shade_idx_s1 <= table_index[SHADE_AW-1:0];
			shade_dat_s1 <= table_data;
		end
	end

	logic [COLOR_W-1:0] shade_color;

	fstm_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (SHADE_DEPTH),
		.AW    (SHADE_AW)
	) u_shade_ram (
		.clk   (clk),
		.we    (adv && shade_we_s1),
		.waddr (shade_idx_s1),
		.wdata (shade_dat_s1),
		.re    (adv),
		.raddr (texel),
		.rdata (shade_color)
	);

	// Framebuffer offset, kept modulo 2^17 like the 17-bit output field.
	logic [COL_W-1:0] row_sum;
	logic [OFF_W-1:0] offset;

	assign row_sum = {1'b0, row_s1} + {1'b0, window_y_q};
	assign offset  = OFF_W'(row_sum) * OFF_W'(SCREEN_WIDTH)
	                 + OFF_W'(window_x_q) + OFF_W'(col_s1);

	// Stage 2: shaded color comes out of the shade RAM.
	logic             last_s2;
	logic [OFF_W-1:0] offset_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2   <= last_s1;
			offset_s2 <= offset;
		end
	end

	// Output register: holds a pixel until the downstream side takes it.
	logic [OFF_W-1:0]   offset_q;
	logic [COLOR_W-1:0] color_q;
	logic               last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (valid_s2 && adv) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && adv) begin
			offset_q <= offset_s2;
			color_q  <= shade_color;
			last_q   <= last_s2;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_DATA_W - OFF_W - COLOR_W)'(0), color_q, offset_q};
	assign m_tlast  = last_q;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the flat span texture mapper. Table entries are
// written on demand, just before the first pixel that would read them, so no
// pixel ever reads an entry that was never written. A short table of
// hand-picked beats comes first, then phases of random span sequences under
// several window settings and random stalls on both streams. Every pixel is
// checked against an in-bench model of the span walk or a pixel typed in.
// ----------------------------------------------------------------------------
module testbench;
	import fstm_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 80;
	localparam int DRAIN_CYCLES = 12;
	localparam int LONG_HOLD    = 150;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic [1:0]       func;
		logic [TEX_AW-1:0] tex_index;
		logic [7:0]       tex_data;
		logic [31:0]      u_start;
		logic [31:0]      v_start;
		logic [31:0]      u_step;
		logic [31:0]      v_step;
		logic [COL_W-1:0] first_x;
		logic [COL_W-1:0] last_x;
		logic [ROW_W-1:0] row;
	} span_beat_t;

	typedef struct packed {
		logic [OFF_W-1:0]   offset;
		logic [COLOR_W-1:0] color;
		logic               last;
	} pixel_t;

	// How a directed row is checked: by the model, as "no pixel", or against
	// a pixel typed into the table.
	typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_PIXEL} check_kind_t;

	typedef struct {
		span_beat_t  beat;
		check_kind_t kind;
		pixel_t      pix;
	} directed_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic                  cfg_index;
	logic [8:0]            cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	// Model state of the span walker.
	logic [COLOR_W-1:0] texel_mem [TEX_DEPTH];
	logic [COLOR_W-1:0] shade_mem [SHADE_DEPTH];
	bit                 texel_set [TEX_DEPTH];
	bit                 shade_set [SHADE_DEPTH];
	logic [31:0]        u_pos, v_pos, u_inc, v_inc;
	logic [COL_W-1:0]   cur_col, end_col;
	logic [ROW_W-1:0]   cur_row;
	logic               span_live;
	logic [8:0]         win_x;
	logic [7:0]         win_y;

	pixel_t        pending_pixels [$];
	directed_row_t directed_rows [$];
	pixel_t        head_pixel;

	int error_count    = 0;
	int pixels_checked = 0;
	int spans_started  = 0;
	int table_writes   = 0;
	int live_items     = 0;
	int cycle_count    = 0;
	int src_idle_pct   = 0;
	int sink_idle_pct  = 0;
	int hold_request   = 0;

	flat_span_texture_mapper_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timed out after %0d cycles with %0d pixels outstanding.",
			cycle_count, pending_pixels.size());
		$display("RESULT: ERROR");
		$finish;
	end

	// Applies one beat to the model and reports the pixel it produces, if any.
	task automatic predict_span_beat(input span_beat_t b, output bit has_pix,
			output pixel_t p);
		int               offset;
		logic [TEX_AW-1:0] addr;
		has_pix = 1'b0;
		p = '0;
		case (b.func)
			FUNC_TEXEL: begin
				texel_mem[b.tex_index] = b.tex_data;
				texel_set[b.tex_index] = 1'b1;
				table_writes++;
			end
			FUNC_SHADE: begin
				shade_mem[b.tex_index[SHADE_AW-1:0]] = b.tex_data;
				shade_set[b.tex_index[SHADE_AW-1:0]] = 1'b1;
				table_writes++;
			end
			FUNC_START: begin
				u_pos = b.u_start;
				v_pos = b.v_start;
				u_inc = b.u_step;
				v_inc = b.v_step;
				cur_col = b.first_x;
				end_col = b.last_x;
				cur_row = b.row;
				span_live = (b.last_x >= b.first_x);
				spans_started++;
			end
			default: begin
				if (span_live) begin
					offset = (int'(cur_row) + int'(win_y)) * SCREEN_WIDTH_DEF
						+ int'(win_x) + int'(cur_col);
					// Integer parts of v and u, six bits each, form the texel address.
					addr = {v_pos[FRAC_W+COORD_W-1:FRAC_W], u_pos[FRAC_W+COORD_W-1:FRAC_W]};
					p.offset = offset[OFF_W-1:0];
					p.color = shade_mem[texel_mem[addr]];
					p.last = (cur_col >= end_col);
					u_pos = u_pos + u_inc;
					v_pos = v_pos + v_inc;
					if (p.last)
						span_live = 1'b0;
					else
						cur_col = cur_col + 1'b1;
					has_pix = 1'b1;
				end
			end
		endcase
	endtask

	function automatic logic [31:0] random_step();
		if ($urandom_range(0, 1))
			return $urandom;
		return 32'($urandom_range(0, 'h7FFFF)) - 32'h0004_0000;
	endfunction

	// Every field random within its range; callers pin what matters.
	function automatic span_beat_t random_beat(input logic [1:0] func);
		span_beat_t b;
		b.func = func;
		b.tex_index = TEX_AW'($urandom_range(0, TEX_DEPTH - 1));
		b.tex_data = 8'($urandom_range(0, 255));
		b.u_start = $urandom;
		b.v_start = $urandom;
		b.u_step = random_step();
		b.v_step = random_step();
		b.first_x = COL_W'($urandom_range(0, 319));
		b.last_x = COL_W'($urandom_range(0, 319));
		b.row = ROW_W'($urandom_range(0, 199));
		return b;
	endfunction

	// Queues the expected pixel, then offers the beat after an optional gap
	// and waits for the handshake. Before a pixel of a live span, any table
	// entry that pixel reads and that holds no value yet is written first.
	task automatic offer_beat(input span_beat_t b, input check_kind_t kind,
			input pixel_t typed);
		bit                has_pix;
		pixel_t            p;
		int                gap;
		logic [TEX_AW-1:0] addr;
		span_beat_t        w;
		if (b.func == FUNC_DRAW && span_live) begin
			addr = {v_pos[FRAC_W+COORD_W-1:FRAC_W], u_pos[FRAC_W+COORD_W-1:FRAC_W]};
			if (!texel_set[addr]) begin
				w = random_beat(FUNC_TEXEL);
				w.tex_index = addr;
				offer_beat(w, CHECK_MODEL, '0);
			end
			if (!shade_set[texel_mem[addr]]) begin
				w = random_beat(FUNC_SHADE);
				w.tex_index = {w.tex_index[TEX_AW-1:SHADE_AW], texel_mem[addr]};
				offer_beat(w, CHECK_MODEL, '0);
			end
		end
		predict_span_beat(b, has_pix, p);
		if (kind == CHECK_PIXEL)
			pending_pixels.push_back(typed);
		else if (kind == CHECK_MODEL && has_pix)
			pending_pixels.push_back(p);
		if (!(b.func == FUNC_DRAW && !has_pix))
			live_items++;
		gap = 0;
		if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct)
			gap = $urandom_range(1, 14);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= b.func;
		s_tdata <= {2'b00, b.row, b.last_x, b.first_x, b.v_step, b.u_step,
			b.v_start, b.u_start, b.tex_data, b.tex_index};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic add_row(input logic [1:0] func, input logic [11:0] idx,
			input logic [7:0] dat, input logic [31:0] u, input logic [31:0] v,
			input logic [31:0] us, input logic [31:0] vs, input logic [8:0] fx,
			input logic [8:0] lx, input logic [7:0] row, input check_kind_t kind,
			input logic [16:0] off, input logic [7:0] color, input logic last);
		directed_row_t r;
		r.beat = '{func, idx, dat, u, v, us, vs, fx, lx, row};
		r.kind = kind;
		r.pix = '{off, color, last};
		directed_rows.push_back(r);
	endtask

	// One random sequence: mostly a well-formed span with its draws, at times
	// a table write, a reversed span, an abandoned span or surplus draws.
	task automatic random_sequence();
		int         r;
		int         len;
		int         draws;
		span_beat_t b;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			repeat ($urandom_range(1, 3))
				offer_beat(random_beat(2'($urandom_range(0, 1))), CHECK_MODEL, '0);
		end else if (r < 18) begin
			b = random_beat(FUNC_START);
			b.first_x = COL_W'($urandom_range(1, 319));
			b.last_x = COL_W'($urandom_range(0, b.first_x - 1));
			offer_beat(b, CHECK_MODEL, '0);
			repeat ($urandom_range(1, 2))
				offer_beat(random_beat(FUNC_DRAW), CHECK_MODEL, '0);
		end else begin
			r = $urandom_range(0, 99);
			if (r < 80)
				len = $urandom_range(1, 8);
			else if (r < 97)
				len = $urandom_range(9, 40);
			else
				len = $urandom_range(41, 320);
			b = random_beat(FUNC_START);
			b.first_x = COL_W'($urandom_range(0, 320 - len));
			b.last_x = COL_W'(int'(b.first_x) + len - 1);
			offer_beat(b, CHECK_MODEL, '0);
			draws = len;
			r = $urandom_range(0, 99);
			// A short count leaves the span to be abandoned by the next start.
			if (r < 10)
				draws = $urandom_range(0, len - 1);
			else if (r < 20)
				draws = len + $urandom_range(1, 2);
			repeat (draws) begin
				if ($urandom_range(0, 19) == 0)
					offer_beat(random_beat(2'($urandom_range(0, 1))), CHECK_MODEL, '0);
				offer_beat(random_beat(FUNC_DRAW), CHECK_MODEL, '0);
			end
		end
	endtask

	// Stops offering and waits until every expected pixel has arrived, then
	// lets the pipeline settle.
	task automatic wait_pixels_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [8:0] wx, input logic [7:0] wy);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_WINDOW_X;
		cfg_data <= wx;
		@(negedge clk);
		cfg_index <= CFG_WINDOW_Y;
		cfg_data <= {1'b0, wy};
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		win_x = wx;
		win_y = wy;
	endtask

	// Output side pacing: random stall bursts, plus one long hold on request.
	initial begin : sink_pacing
		int n;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				n = hold_request;
				hold_request = 0;
				m_tready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14) - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Pixel checker: each output beat against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel: screen_offset %0d pixel_color %0d last_pixel %0b",
					m_tdata[16:0], m_tdata[24:17], m_tlast);
				error_count++;
			end else begin
				head_pixel = pending_pixels.pop_front();
				if (m_tdata[16:0] !== head_pixel.offset) begin
					$error("screen_offset: expected %0d, actual %0d",
						head_pixel.offset, m_tdata[16:0]);
					error_count++;
				end
				if (m_tdata[24:17] !== head_pixel.color) begin
					$error("pixel_color: expected %0d, actual %0d",
						head_pixel.color, m_tdata[24:17]);
					error_count++;
				end
				if (m_tlast !== head_pixel.last) begin
					$error("last_pixel: expected %0b, actual %0b",
						head_pixel.last, m_tlast);
					error_count++;
				end
			end
			pixels_checked++;
		end
	end

	initial begin : stimulus
		int         wx_tab [PHASES];
		int         wy_tab [PHASES];
		int         src_tab [PHASES];
		int         sink_tab [PHASES];
		bit         paused;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_WINDOW_X;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = FUNC_TEXEL;
		u_pos = '0;
		v_pos = '0;
		u_inc = '0;
		v_inc = '0;
		cur_col = '0;
		end_col = '0;
		cur_row = '0;
		span_live = 1'b0;
		win_x = '0;
		win_y = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Hand-picked beats at the reset window.
		src_idle_pct = 10;
		sink_idle_pct = 10;
		// A draw before any start has no span to walk.
		add_row(FUNC_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 0, CHECK_NONE, 0, 0, 0);
		// Single pixel at the framebuffer origin.
		add_row(FUNC_TEXEL, 12'h000, 8'h5A, 0, 0, 0, 0, 0, 0, 0, CHECK_MODEL, 0, 0, 0);
		add_row(FUNC_SHADE, 12'h05A, 8'hC3, 0, 0, 0, 0, 0, 0, 0, CHECK_MODEL, 0, 0, 0);
		add_row(FUNC_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, CHECK_NONE, 0, 0, 0);
		add_row(FUNC_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 0, CHECK_PIXEL, 17'd0, 8'hC3, 1'b1);
		add_row(FUNC_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 0, CHECK_NONE, 0, 0, 0);
		// Far corner of texture and screen; the shade write with high index
		// bits set must land on entry 0x11.
		add_row(FUNC_TEXEL, 12'hFFF, 8'hFF, 0, 0, 0, 0, 0, 0, 0, CHECK_MODEL, 0, 0, 0);
		add_row(FUNC_SHADE, 12'h0FF, 8'h00, 0, 0, 0, 0, 0, 0, 0, CHECK_MODEL, 0, 0, 0);
		add_row(FUNC_SHADE, 12'hF11, 8'hEE, 0, 0, 0, 0, 0, 0, 0, CHECK_MODEL, 0, 0, 0);
		add_row(FUNC_START, 0, 0, 32'h003F_8000, 32'h003F_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
			9'd319, 9'd319, 8'd199, CHECK_NONE, 0, 0, 0);
		add_row(FUNC_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 0, CHECK_PIXEL, 17'd63999, 8'h00, 1'b1);
		// Reversed span: nothing to draw.
		add_row(FUNC_START, 0, 0, 0, 0, 0, 0, 9'd10, 9'd9, 8'd50, CHECK_NONE, 0, 0, 0);
		add_row(FUNC_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 0, CHECK_NONE, 0, 0, 0);
		// Positions that wrap around the 32-bit range.
		add_row(FUNC_START, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_0000,
			9'd316, 9'd319, 8'd100, CHECK_MODEL, 0, 0, 0);
		repeat (4)
			add_row(FUNC_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 0, CHECK_MODEL, 0, 0, 0);
		// Full-width span, abandoned after two pixels by a restart.
		add_row(FUNC_START, 0, 0, 32'hFFFF_0000, 32'h0, 32'h0001_0000, 32'h0001_0000,
			9'd0, 9'd319, 8'd0, CHECK_MODEL, 0, 0, 0);
		repeat (2)
			add_row(FUNC_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 0, CHECK_MODEL, 0, 0, 0);
		add_row(FUNC_START, 0, 0, 32'h0012_0000, 32'h0034_0000, 32'hFFFF_8000, 32'h0001_8000,
			9'd100, 9'd101, 8'd199, CHECK_MODEL, 0, 0, 0);
		repeat (3)
			add_row(FUNC_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 0, CHECK_MODEL, 0, 0, 0);
		foreach (directed_rows[i])
			offer_beat(directed_rows[i].beat, directed_rows[i].kind, directed_rows[i].pix);

		// Random phases, each under its own window and pacing. The last one
		// runs with no idling at all.
		wx_tab = '{319, 0, $urandom_range(0, 319), 0, 319, $urandom_range(0, 319)};
		wy_tab = '{199, 0, $urandom_range(0, 199), 199, 0, $urandom_range(0, 199)};
		src_tab = '{10, 0, 25, 5, 15, 0};
		sink_tab = '{10, 15, 5, 25, 15, 0};
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_pixels_drained();
			write_window(9'(wx_tab[ph]), 8'(wy_tab[ph]));
			src_idle_pct = src_tab[ph];
			sink_idle_pct = sink_tab[ph];
			live_items = 0;
			paused = 1'b0;
			// Long output hold while the input keeps streaming, so the block
			// fills up and pushes back.
			if (ph == 1)
				hold_request = LONG_HOLD;
			while (live_items < PHASE_ITEMS) begin
				random_sequence();
				if (ph == 3 && !paused && live_items >= PHASE_ITEMS / 2) begin
					paused = 1'b1;
					wait_pixels_drained();
				end
			end
		end

		wait_pixels_drained();
		$display("Ran %0d table writes and %0d span starts under %0d window settings.",
			table_writes, spans_started, PHASES + 1);
		$display("Checked %0d pixels, %0d mismatches.", pixels_checked, error_count);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- flat_span_texture_mapper_top.f -----
hw/rtl/fstm_pkg.sv
hw/rtl/fstm_ram.sv
hw/rtl/fstm_span.sv
hw/rtl/flat_span_texture_mapper_top.sv
test/testbench.sv
